[hw/rtl/bmh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and constants of the mice-to-holes matcher
// Mode codes, sequencer states and size defaults.
// ----------------------------------------------------------------------------
package bmh_pkg;
   localparam int MAX_MICE_DEF  = 64;
   localparam int MAX_HOLES_DEF = 64;
   localparam int POS_W         = 32;
   localparam int COST_W        = 33;

   typedef enum logic [1:0] {
      MODE_MOUSE = 2'd0,
      MODE_HOLE  = 2'd1,
      MODE_SOLVE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_END,
      ST_SOL_INIT,
      ST_ROW_START,
      ST_ROW_RD,
      ST_CELL,
      ST_ROW_END,
      ST_FINAL_RD,
      ST_FINAL,
      ST_EMIT
   } state_type;
endpackage

[hw/rtl/bmh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram: generic single-port RAM
// One access per cycle, registered read data (old contents on a write).
// ----------------------------------------------------------------------------
module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

[hw/rtl/bmh_cell_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_cell_unit: shared distance / max / min unit
// Computes min(cur, max(|m-h|, next)) for one table cell per cycle.
// ----------------------------------------------------------------------------
module bmh_cell_unit
   import bmh_pkg::*;
(
   input  logic [POS_W-1:0]  mouse,
   input  logic [POS_W-1:0]  hole,
   input  logic [COST_W-1:0] next_cost,
   input  logic [COST_W-1:0] cur_cost,
   output logic [COST_W-1:0] cell_cost
);
   logic signed [POS_W:0] diff;
   logic [COST_W-1:0]     gap_abs;
   logic [COST_W-1:0]     worst;

   always_comb begin
      diff    = $signed({mouse[POS_W-1], mouse}) - $signed({hole[POS_W-1], hole});
      gap_abs = diff[POS_W] ? COST_W'(-diff) : COST_W'(diff);
      worst   = (next_cost > gap_abs) ? next_cost : gap_abs;
      cell_cost = (worst < cur_cost) ? worst : cur_cost;
   end
endmodule

[hw/rtl/bottleneck_mice_to_holes_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bottleneck_mice_to_holes_matcher: bottleneck matching of mice to holes
// Sorted mouse and hole stores with an order-preserving min-max table solve.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_mode and req_position while busy is low; the
//   transaction is taken at that edge. Mode 0 inserts a mouse, mode 1 a hole,
//   each into its sorted store, and busy rises on the next cycle; a load
//   beyond capacity and mode 3 are dropped with busy staying low.
//   Mode 2 solves: rsp_valid pulses for one cycle with rsp_min_max_distance
//   and rsp_feasible, then both stores are emptied.
// Sequencing:
//   A load moves each entry past the new position up one slot, in a read
//   state and a compare state, then writes the new entry. A feasible solve
//   visits each table cell in a read state and a cell state through the
//   single shared cell unit and the single-port row RAMs; a solve with
//   fewer holes than mice skips the table. One transaction at a time.
// Reset:
//   Reset empties both stores and returns the sequencer to idle.
//   The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module bottleneck_mice_to_holes_matcher
   import bmh_pkg::*;
#(
   parameter int MAX_MICE  = MAX_MICE_DEF,
   parameter int MAX_HOLES = MAX_HOLES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_mode,
   input  logic [31:0]      req_position,
   output logic             rsp_valid,
   output logic [31:0]      rsp_min_max_distance,
   output logic             rsp_feasible
);
   localparam int MA_W = (MAX_MICE > 1) ? $clog2(MAX_MICE) : 1;
   localparam int HA_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int MC_W = $clog2(MAX_MICE + 1);
   localparam int HC_W = $clog2(MAX_HOLES + 1);
   localparam int P_W  = (MC_W > HC_W) ? MC_W : HC_W;
   localparam int CD   = MAX_HOLES + 1;
   localparam int CA_W = $clog2(CD);
   localparam int MS_D = (MAX_MICE > 1) ? MAX_MICE : 2;
   localparam int HS_D = (MAX_HOLES > 1) ? MAX_HOLES : 2;

   state_type state_ff, state_in;

   logic [MC_W-1:0]  mcnt_ff, mcnt_in;
   logic [HC_W-1:0]  hcnt_ff, hcnt_in;
   logic             is_hole_ff, is_hole_in;
   logic [POS_W-1:0] val_ff, val_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [MC_W-1:0]  i_ff, i_in;
   logic [HC_W-1:0]  j_ff, j_in;
   logic             nx_ff, nx_in;
   logic [COST_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] m_ff, m_in;
   logic [COST_W-1:0] res_ff, res_in;

   // store and row RAM controls
   logic             ms_we, hs_we;
   logic [MA_W-1:0]  ms_addr;
   logic [HA_W-1:0]  hs_addr;
   logic [POS_W-1:0] ms_wd, hs_wd, ms_rd, hs_rd, st_rd;
   logic             c0_we, c1_we;
   logic [CA_W-1:0]  c0_addr, c1_addr;
   logic [COST_W-1:0] c_wd, c0_rd, c1_rd, next_rd;
   logic [COST_W-1:0] cell_cost;

   bmh_ram #(.WIDTH(POS_W), .DEPTH(MS_D)) u_mice (
      .clock(clock), .wr_en(ms_we), .addr(ms_addr), .wr_data(ms_wd), .rd_data(ms_rd));
   bmh_ram #(.WIDTH(POS_W), .DEPTH(HS_D)) u_holes (
      .clock(clock), .wr_en(hs_we), .addr(hs_addr), .wr_data(hs_wd), .rd_data(hs_rd));
   bmh_ram #(.WIDTH(COST_W), .DEPTH(CD)) u_row0 (
      .clock(clock), .wr_en(c0_we), .addr(c0_addr), .wr_data(c_wd), .rd_data(c0_rd));
   bmh_ram #(.WIDTH(COST_W), .DEPTH(CD)) u_row1 (
      .clock(clock), .wr_en(c1_we), .addr(c1_addr), .wr_data(c_wd), .rd_data(c1_rd));

   bmh_cell_unit u_cell (
      .mouse(m_ff), .hole(hs_rd), .next_cost(next_rd), .cur_cost(cur_ff),
      .cell_cost(cell_cost));

   assign st_rd   = is_hole_ff ? hs_rd : ms_rd;
   assign next_rd = nx_ff ? c1_rd : c0_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mcnt_ff  <= '0;
         hcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mcnt_ff  <= mcnt_in;
         hcnt_ff  <= hcnt_in;
      end
      is_hole_ff <= is_hole_in;
      val_ff     <= val_in;
      p_ff       <= p_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      nx_ff      <= nx_in;
      cur_ff     <= cur_in;
      m_ff       <= m_in;
      res_ff     <= res_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (mode_type'(req_mode))
                  MODE_MOUSE: state_in = (mcnt_ff < MC_W'(MAX_MICE)) ?
                                         ST_INS_RD : ST_IDLE;
                  MODE_HOLE:  state_in = (hcnt_ff < HC_W'(MAX_HOLES)) ?
                                         ST_INS_RD : ST_IDLE;
                  MODE_SOLVE: state_in = (32'(hcnt_ff) < 32'(mcnt_ff)) ? ST_EMIT :
                                         ST_SOL_INIT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_RD:    state_in = (p_ff == '0) ? ST_INS_END : ST_INS_CMP;
         ST_INS_CMP:   state_in = ($signed(st_rd) > $signed(val_ff)) ?
                                  ST_INS_RD : ST_INS_END;
         ST_INS_END:   state_in = ST_IDLE;
         ST_SOL_INIT:  state_in = (j_ff == hcnt_ff) ?
                                  ((mcnt_ff == '0) ? ST_FINAL_RD : ST_ROW_START) :
                                  ST_SOL_INIT;
         ST_ROW_START: state_in = (hcnt_ff == '0) ? ST_ROW_END : ST_ROW_RD;
         ST_ROW_RD:    state_in = ST_CELL;
         ST_CELL:      state_in = (j_ff == HC_W'(1)) ? ST_ROW_END : ST_ROW_RD;
         ST_ROW_END:   state_in = (i_ff == MC_W'(1)) ? ST_FINAL_RD : ST_ROW_START;
         ST_FINAL_RD:  state_in = ST_FINAL;
         ST_FINAL:     state_in = ST_EMIT;
         ST_EMIT:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mcnt_in    = mcnt_ff;
      hcnt_in    = hcnt_ff;
      is_hole_in = is_hole_ff;
      val_in     = val_ff;
      p_in       = p_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      nx_in      = nx_ff;
      cur_in     = cur_ff;
      m_in       = m_ff;
      res_in     = res_ff;
      ms_we      = 1'b0;
      hs_we      = 1'b0;
      ms_addr    = '0;
      hs_addr    = '0;
      ms_wd      = val_ff;
      hs_wd      = val_ff;
      c0_we      = 1'b0;
      c1_we      = 1'b0;
      c0_addr    = '0;
      c1_addr    = '0;
      c_wd       = '0;
      busy       = (state_ff != ST_IDLE);
      rsp_valid  = 1'b0;
      rsp_min_max_distance = res_ff[31:0];
      rsp_feasible         = ~res_ff[32];
      unique case (state_ff)
         ST_IDLE: begin
            is_hole_in = (req_mode == MODE_HOLE);
            val_in     = req_position;
            p_in       = (req_mode == MODE_HOLE) ? P_W'(hcnt_ff) : P_W'(mcnt_ff);
            j_in       = '0;
            nx_in      = 1'b0;
            res_in     = {1'b1, 32'd0};
         end
         ST_INS_RD: begin
            ms_addr = MA_W'(p_ff - P_W'(1));
            hs_addr = HA_W'(p_ff - P_W'(1));
         end
         ST_INS_CMP: begin
            // shift the larger entry up one slot
            if ($signed(st_rd) > $signed(val_ff)) begin
               ms_addr = MA_W'(p_ff);
               hs_addr = HA_W'(p_ff);
               ms_wd   = st_rd;
               hs_wd   = st_rd;
               ms_we   = ~is_hole_ff;
               hs_we   = is_hole_ff;
               p_in    = p_ff - P_W'(1);
            end
         end
         ST_INS_END: begin
            ms_addr = MA_W'(p_ff);
            hs_addr = HA_W'(p_ff);
            ms_we   = ~is_hole_ff;
            hs_we   = is_hole_ff;
            if (is_hole_ff) hcnt_in = hcnt_ff + HC_W'(1);
            else            mcnt_in = mcnt_ff + MC_W'(1);
         end
         ST_SOL_INIT: begin
            c0_we   = 1'b1;
            c0_addr = CA_W'(j_ff);
            c_wd    = '0;
            j_in    = j_ff + HC_W'(1);
            i_in    = mcnt_ff;
         end
         ST_ROW_START: begin
            ms_addr = MA_W'(i_ff - MC_W'(1));
            cur_in  = {1'b1, 32'd0};
            j_in    = hcnt_ff;
            // write the infeasible sentinel at the end of the current row
            c_wd    = {1'b1, 32'd0};
            c0_addr = CA_W'(hcnt_ff);
            c1_addr = CA_W'(hcnt_ff);
            c0_we   = nx_ff;
            c1_we   = ~nx_ff;
         end
         ST_ROW_RD: begin
            if (j_ff == hcnt_ff) m_in = ms_rd;
            hs_addr = HA_W'(j_ff - HC_W'(1));
            c0_addr = CA_W'(j_ff);
            c1_addr = CA_W'(j_ff);
         end
         ST_CELL: begin
            if (j_ff == hcnt_ff) m_in = m_ff;
            cur_in  = cell_cost;
            c_wd    = cell_cost;
            c0_addr = CA_W'(j_ff - HC_W'(1));
            c1_addr = CA_W'(j_ff - HC_W'(1));
            c0_we   = nx_ff;
            c1_we   = ~nx_ff;
            j_in    = j_ff - HC_W'(1);
         end
         ST_ROW_END: begin
            nx_in = ~nx_ff;
            i_in  = i_ff - MC_W'(1);
         end
         ST_FINAL_RD: begin
            c0_addr = '0;
            c1_addr = '0;
         end
         ST_FINAL: begin
            res_in = next_rd;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (res_ff[32]) rsp_min_max_distance = '0;
            mcnt_in = '0;
            hcnt_in = '0;
         end
         default: ;
      endcase
   end

   property p_emit_clears;
      @(posedge clock) disable iff (reset) rsp_valid |=> (mcnt_ff == '0 && hcnt_ff == '0);
   endproperty
   a_emit_clears: assert property (p_emit_clears) else $error("stores not emptied");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (mcnt_ff <= MC_W'(MAX_MICE) && hcnt_ff <= HC_W'(MAX_HOLES)))
      else $error("store count overflow");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |=> !busy))
      else $error("busy after result");
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bottleneck mice-to-holes matcher
// Loads mice and holes in batches, solves, and compares each reported
// min-max distance and feasible flag against an in-bench sorted-store and
// min-max table calculation. Covers empty solves, infeasible sets, full
// stores with dropped loads, ignored codes, equal and extreme positions.
// ----------------------------------------------------------------------------
module tb_top
   import bmh_pkg::*;
();

   localparam int CAP        = 64;
   localparam int STALL_LIMIT = 40000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] position;
   } load_item_type;

   typedef struct packed {
      logic [31:0] distance;
      logic        feasible;
   } match_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [31:0] req_position;
   logic        rsp_valid;
   logic [31:0] rsp_min_max_distance;
   logic        rsp_feasible;

   load_item_type pending_q[$];
   match_type     match_q[$];

   logic signed [31:0] mice[CAP];
   logic signed [31:0] holes[CAP];
   int          n_mice;
   int          n_holes;
   int          errors;
   int          solves_seen;
   int          cycle_count;
   int          stall_count;
   int          wait_count;
   bit          hold_off;
   bit          no_idle;

   bottleneck_mice_to_holes_matcher u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_min_max_distance(rsp_min_max_distance),
      .rsp_feasible(rsp_feasible)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [32:0] pos_gap(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [33:0] d;
      d = 34'(a) - 34'(b);
      if (d < 0) d = -d;
      return d[32:0];
   endfunction

   task automatic insert_sorted(input logic signed [31:0] v, input bit is_hole);
      int p;
      if (is_hole) begin
         if (n_holes >= CAP) return;
         p = n_holes;
         while (p > 0 && holes[p-1] > v) begin
            holes[p] = holes[p-1];
            p--;
         end
         holes[p] = v;
         n_holes++;
      end else begin
         if (n_mice >= CAP) return;
         p = n_mice;
         while (p > 0 && mice[p-1] > v) begin
            mice[p] = mice[p-1];
            p--;
         end
         mice[p] = v;
         n_mice++;
      end
   endtask

   function automatic match_type solve_match();
      logic [32:0] nxt[CAP+1];
      logic [32:0] cur[CAP+1];
      logic [32:0] d;
      logic [32:0] v;
      match_type r;
      for (int j = 0; j <= n_holes; j++) nxt[j] = '0;
      if (n_holes < n_mice) begin
         r.distance = '0;
         r.feasible = 1'b0;
         return r;
      end
      for (int i = n_mice; i > 0; i--) begin
         cur[n_holes] = 33'h1_0000_0000;
         for (int j = n_holes; j > 0; j--) begin
            d = pos_gap(mice[i-1], holes[j-1]);
            v = (nxt[j] > d) ? nxt[j] : d;
            cur[j-1] = (v < cur[j]) ? v : cur[j];
         end
         nxt = cur;
      end
      r.feasible = ~nxt[0][32];
      r.distance = nxt[0][32] ? 32'd0 : nxt[0][31:0];
      return r;
   endfunction

   task automatic push(input mode_type m, input logic [31:0] p);
      load_item_type it;
      it.mode = m;
      it.position = p;
      pending_q.push_back(it);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7fff_ffff - $urandom_range(0, 3);
         default: return $urandom_range(0, 400) - 200;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      load_item_type it;
      if (reset) begin
         start <= 1'b0;
         req_mode <= MODE_MOUSE;
         req_position <= '0;
      end else if (start && !busy) begin
         start <= 1'b0;
      end else if (!start && !hold_off && pending_q.size() > 0 &&
                   (no_idle || $urandom_range(0, 99) >= 32)) begin
         it = pending_q.pop_front();
         req_mode <= it.mode;
         req_position <= it.position;
         start <= 1'b1;
         if (it.mode == MODE_SOLVE || it.mode == MODE_MOUSE || it.mode == MODE_HOLE ||
             it.mode == MODE_NONE) begin
            if (it.mode == MODE_MOUSE) insert_sorted(it.position, 1'b0);
            else if (it.mode == MODE_HOLE) insert_sorted(it.position, 1'b1);
            else if (it.mode == MODE_SOLVE) begin
               match_q.push_back(solve_match());
               n_mice = 0;
               n_holes = 0;
            end
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      match_type e;
      if (!reset) begin
         cycle_count++;
         if ((start && !busy) || rsp_valid) stall_count = 0;
         else stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("%0t watchdog: no progress", $time);
            $display("RESULT: ERROR");
            $finish;
         end else if (rsp_valid) begin
            solves_seen++;
            if (match_q.size() == 0) begin
               $display("%0t unexpected result dist=%0d feas=%0b", $time,
                        rsp_min_max_distance, rsp_feasible);
               errors++;
            end else begin
               e = match_q.pop_front();
               if (rsp_min_max_distance !== e.distance) begin
                  $display("%0t distance mismatch expected %0d actual %0d", $time,
                           e.distance, rsp_min_max_distance);
                  errors++;
               end
               if (rsp_feasible !== e.feasible) begin
                  $display("%0t feasible mismatch expected %0b actual %0b", $time,
                           e.feasible, rsp_feasible);
                  errors++;
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || start || busy || match_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int nm;
      int nh;
      int items;
      errors = 0;
      solves_seen = 0;
      cycle_count = 0;
      stall_count = 0;
      n_mice = 0;
      n_holes = 0;
      hold_off = 1'b0;
      no_idle = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      push(MODE_SOLVE, 32'h0);
      push(MODE_MOUSE, 32'h8000_0000);
      push(MODE_SOLVE, 32'hffff_ffff);
      push(MODE_MOUSE, 32'h8000_0000);
      push(MODE_HOLE, 32'h7fff_ffff);
      push(MODE_SOLVE, 32'h0);
      push(MODE_MOUSE, 32'h7fff_ffff);
      push(MODE_HOLE, 32'h8000_0000);
      push(MODE_NONE, 32'h5);
      push(MODE_SOLVE, 32'h0);
      push(MODE_MOUSE, 32'd5);
      push(MODE_MOUSE, 32'd5);
      push(MODE_MOUSE, -32'sd1);
      push(MODE_HOLE, 32'd5);
      push(MODE_HOLE, -32'sd5);
      push(MODE_HOLE, 32'd5);
      push(MODE_HOLE, 32'd200000000);
      push(MODE_SOLVE, 32'h0);
      push(MODE_NONE, 32'hffff_ffff);
      push(MODE_HOLE, 32'd0);
      push(MODE_SOLVE, 32'h0);
      wait_drained();

      // full stores and dropped loads
      for (int k = 0; k < CAP + 2; k++) push(MODE_MOUSE, rand_pos());
      for (int k = 0; k < CAP + 2; k++) push(MODE_HOLE, rand_pos());
      push(MODE_SOLVE, 32'h0);

      // send everything, then hold off until drained
      while (pending_q.size() > 0) @(posedge clock);
      hold_off = 1'b1;
      wait_drained();
      hold_off = 1'b0;

      items = 0;
      while (items < 1900) begin
         if (items > 600 && items < 900) no_idle = 1'b1;
         else no_idle = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            push(mode_type'($urandom_range(0, 3)), $urandom());
            items++;
         end else begin
            nm = ($urandom_range(0, 19) == 0) ? $urandom_range(0, CAP + 1)
                                              : $urandom_range(0, 6);
            nh = ($urandom_range(0, 5) == 0) ? (nm > 0 ? nm - 1 : 0)
                                             : nm + $urandom_range(0, 4);
            for (int k = 0; k < nm + nh; k++) begin
               if (k < nm) push(MODE_MOUSE, rand_pos());
               else push(MODE_HOLE, rand_pos());
            end
            push(MODE_SOLVE, $urandom());
            items += nm + nh + 1;
         end
         while (pending_q.size() > 40) @(posedge clock);
      end
      wait_drained();
      wait_count = 0;
      while (wait_count < 20000 && busy) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (20) @(posedge clock);
      $display("Covered %0d solves over %0d cycles: empty, infeasible, full stores,",
               solves_seen, cycle_count);
      $display("dropped loads, ignored codes and extreme coordinates.");
      if (errors == 0 && match_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
